// ===== rtl/tcg_pkg.sv =====
// ----------------------------------------------------------------------------
// tcg_pkg: shared definitions of the text console glyph renderer
// Field widths, font geometry, item and command codes, queue and back-end types.
// ----------------------------------------------------------------------------
package tcg_pkg;

  // font geometry
  localparam int GLYPH_HEIGHT = 16;
  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_COUNT  = 128;
  localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int TAB_ADVANCE  = 4 * GLYPH_WIDTH;

  // field widths
  localparam int MODE_W  = 2;
  localparam int CODE_W  = 8;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int ROW_W   = $clog2(GLYPH_HEIGHT);
  localparam int GIDX_W  = ADDR_W - ROW_W;
  localparam int MASK_W  = GLYPH_WIDTH;
  localparam int LINES_W = 12;
  localparam int X_W     = 12;
  localparam int Y_W     = 16;

  // screen width after reset
  localparam logic [X_W-1:0] SCREEN_WIDTH_RST = 12'd640;

  // control characters
  localparam logic [CODE_W-1:0] CHAR_TAB     = 8'd9;
  localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'd10;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_DRAW   = 2'd0,
    MODE_FONT   = 2'd1,
    MODE_SCROLL = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_FONT = 1'b1
  } cmd_kind_e;

  // one queued command: a glyph to draw at a cursor, or a font byte to store
  typedef struct packed {
    cmd_kind_e          kind;
    logic [ADDR_W-1:0]  addr;
    logic [MASK_W-1:0]  data;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DRAW = 1'b1
  } back_state_e;

endpackage

// ===== rtl/tcg_ifs.sv =====
// ----------------------------------------------------------------------------
// tcg channel interfaces
// Valid/ready channels for input items, glyph rows and the width register.
// ----------------------------------------------------------------------------

interface tcg_in_if;
  import tcg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [CODE_W-1:0]    char_code;
  logic [ADDR_W-1:0]    font_address;
  logic [MASK_W-1:0]    font_byte;
  logic [LINES_W-1:0]   scroll_lines;

  modport source (output valid, mode, char_code, font_address, font_byte, scroll_lines,
                  input ready);
  modport sink   (input valid, mode, char_code, font_address, font_byte, scroll_lines,
                  output ready);
endinterface

interface tcg_out_if;
  import tcg_pkg::*;
  logic               valid;
  logic               ready;
  logic [X_W-1:0]     pixel_x;
  logic [Y_W-1:0]     pixel_y;
  logic [MASK_W-1:0]  row_mask;
  logic               last_row;

  modport source (output valid, pixel_x, pixel_y, row_mask, last_row, input ready);
  modport sink   (input valid, pixel_x, pixel_y, row_mask, last_row, output ready);
endinterface

interface tcg_cfg_if;
  import tcg_pkg::*;
  logic            valid;
  logic            ready;
  logic [X_W-1:0]  screen_width;

  modport source (output valid, screen_width, input ready);
  modport sink   (input valid, screen_width, output ready);
endinterface

// ===== rtl/tcg_front.sv =====
// ----------------------------------------------------------------------------
// tcg_front: item intake and cursor tracking
// Accepts items, advances the cursor, and queues draw and font-write commands.
// ----------------------------------------------------------------------------
module tcg_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  tcg_in_if.sink             in_i,
  tcg_cfg_if.sink            cfg_i,
  input  tcg_pkg::q_status_t q_status_i,
  output logic               push_o,
  output tcg_pkg::cmd_t      cmd_o
);
  import tcg_pkg::*;

  logic [X_W-1:0] width_q;
  logic [X_W-1:0] cursor_x_q, cursor_x_d;
  logic [Y_W-1:0] cursor_y_q, cursor_y_d;

  logic           accept;
  logic           is_newline;
  logic           is_tab;
  logic           drawable;
  logic [X_W:0]   next_x;
  logic [Y_W-1:0] base_y;
  logic           wrap;
  logic [Y_W-1:0] lines_ext;

  // handshakes
  assign in_i.ready  = !q_status_i.full;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;

  // character classification
  assign is_newline = (in_i.char_code == CHAR_NEWLINE);
  assign is_tab     = (in_i.char_code == CHAR_TAB);
  assign drawable   = (in_i.char_code < CODE_W'(GLYPH_COUNT));
  assign lines_ext  = Y_W'(in_i.scroll_lines);

  // cursor advance and wrap, compared at full width
  always_comb begin
    base_y = is_newline ? cursor_y_q + Y_W'(GLYPH_HEIGHT) : cursor_y_q;
    if (is_newline) begin
      next_x = '0;
    end else if (is_tab) begin
      next_x = {1'b0, cursor_x_q} + (X_W+1)'(TAB_ADVANCE);
    end else begin
      next_x = {1'b0, cursor_x_q} + (X_W+1)'(GLYPH_WIDTH);
    end
    wrap = (next_x >= {1'b0, width_q});
  end

  // next cursor per mode
  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    case (mode_e'(in_i.mode))
      MODE_DRAW: begin
        if (wrap) begin
          cursor_x_d = '0;
          cursor_y_d = base_y + Y_W'(GLYPH_HEIGHT);
        end else begin
          cursor_x_d = next_x[X_W-1:0];
          cursor_y_d = base_y;
        end
      end
      MODE_SCROLL: begin
        cursor_y_d = (cursor_y_q >= lines_ext) ? cursor_y_q - lines_ext : '0;
      end
      default: begin
        cursor_x_d = cursor_x_q;
        cursor_y_d = cursor_y_q;
      end
    endcase
  end

  // command to the back end
  always_comb begin
    push_o     = 1'b0;
    cmd_o.kind = CMD_DRAW;
    cmd_o.addr = ADDR_W'({in_i.char_code, {ROW_W{1'b0}}});
    cmd_o.data = in_i.font_byte;
    cmd_o.x    = cursor_x_q;
    cmd_o.y    = cursor_y_q;
    case (mode_e'(in_i.mode))
      MODE_DRAW: begin
        push_o = accept && drawable;
      end
      MODE_FONT: begin
        push_o     = accept;
        cmd_o.kind = CMD_FONT;
        cmd_o.addr = in_i.font_address;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  // width register and cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= SCREEN_WIDTH_RST;
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        width_q <= cfg_i.screen_width;
      end
      if (accept) begin
        cursor_x_q <= cursor_x_d;
        cursor_y_q <= cursor_y_d;
      end
    end
  end

endmodule

// ===== rtl/tcg_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// tcg_cmd_queue: command fifo between front and back
// Small register fifo so the intake and the row emitter stall independently.
// ----------------------------------------------------------------------------
module tcg_cmd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tcg_pkg::cmd_t      cmd_i,
  input  logic               pop_i,
  output tcg_pkg::cmd_t      cmd_o,
  output tcg_pkg::q_status_t status_o
);
  import tcg_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  logic do_push;
  logic do_pop;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign cmd_o          = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/tcg_back.sv =====
// ----------------------------------------------------------------------------
// tcg_back: font store and glyph row emitter
// Executes queued commands: stores font bytes, reads and emits glyph rows.
// ----------------------------------------------------------------------------
module tcg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcg_pkg::q_status_t q_status_i,
  input  tcg_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  tcg_out_if.source          out_o
);
  import tcg_pkg::*;

  // font memory
  logic [MASK_W-1:0] font_mem_q [STORE_DEPTH];
  logic [MASK_W-1:0] rdata_q;

  back_state_e       state_q, state_d;
  logic [ROW_W-1:0]  row_q;
  logic [GIDX_W-1:0] glyph_q;
  logic [X_W-1:0]    x_q;
  logic [Y_W-1:0]    y_q;

  // row whose font byte is in rdata_q
  logic              pend_valid_q;
  logic [X_W-1:0]    pend_x_q;
  logic [Y_W-1:0]    pend_y_q;
  logic              pend_last_q;

  // output register
  logic              out_valid_q;
  logic [X_W-1:0]    out_x_q;
  logic [Y_W-1:0]    out_y_q;
  logic [MASK_W-1:0] out_mask_q;
  logic              out_last_q;

  logic pend_move;
  logic issue;
  logic load_draw;
  logic mem_we;
  logic last_issue;

  assign pend_move  = pend_valid_q && (!out_valid_q || out_o.ready);
  assign issue      = (state_q == BK_DRAW) && (!pend_valid_q || pend_move);
  assign last_issue = issue && (row_q == ROW_W'(GLYPH_HEIGHT - 1));
  assign load_draw  = pop_o && (cmd_i.kind == CMD_DRAW);
  assign mem_we     = pop_o && (cmd_i.kind == CMD_FONT);

  // command sequencer
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          if (cmd_i.kind == CMD_DRAW) begin
            state_d = BK_DRAW;
          end
        end
      end
      BK_DRAW: begin
        if (last_issue) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // font store write and row read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      font_mem_q[cmd_i.addr] <= cmd_i.data;
    end
    if (issue) begin
      rdata_q <= font_mem_q[{glyph_q, row_q}];
    end
  end

  // glyph context and row payloads
  always_ff @(posedge clk_i) begin
    if (load_draw) begin
      glyph_q <= cmd_i.addr[ADDR_W-1:ROW_W];
      x_q     <= cmd_i.x;
      y_q     <= cmd_i.y;
    end
    if (issue) begin
      pend_x_q    <= x_q;
      pend_y_q    <= y_q + Y_W'(row_q);
      pend_last_q <= (row_q == ROW_W'(GLYPH_HEIGHT - 1));
    end
    if (pend_move) begin
      out_x_q    <= pend_x_q;
      out_y_q    <= pend_y_q;
      out_mask_q <= rdata_q;
      out_last_q <= pend_last_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      row_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_draw) begin
        row_q <= '0;
      end else if (issue) begin
        row_q <= row_q + 1'b1;
      end
      if (issue) begin
        pend_valid_q <= 1'b1;
      end else if (pend_move) begin
        pend_valid_q <= 1'b0;
      end
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.pixel_x  = out_x_q;
  assign out_o.pixel_y  = out_y_q;
  assign out_o.row_mask = out_mask_q;
  assign out_o.last_row = out_last_q;

endmodule

// ===== rtl/text_console_glyph_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_unit: 8x16 bitmap font text console
// Tracks a pixel cursor, holds a 128-glyph font and emits glyph rows.
// ----------------------------------------------------------------------------
// A drawn character (mode 0, code below 128, tab and newline included)
// produces sixteen row beats, one per cycle while the output is taken, once
// the back end has taken the command; the row rate is set by the single read
// port of the font memory, one glyph row per read. Font writes are executed
// in the back end; undrawn codes and scrolls finish in the intake and overlap
// with drawing as long as the two-entry command queue has room. Font bytes
// never written read as undefined. The screen width register may only be
// written while no characters are in flight.
module text_console_glyph_renderer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcg_in_if.sink     in_i,
  tcg_out_if.source  out_o,
  tcg_cfg_if.sink    cfg_i
);
  import tcg_pkg::*;

  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  q_status_t q_status;

  // intake and cursor
  tcg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // command queue
  tcg_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  // font store and row emitter
  tcg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .out_o      (out_o)
  );

`ifndef NO_ASSERTIONS
  // intake never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("command pushed into full queue");

  // back end never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("command popped from empty queue");

  // queue cannot be full and empty at once
  a_q_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty");
`endif

endmodule
